// ----- rtl/core/stg_pkg.sv -----
package stg_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int PIXEL_BITS_DEF = 8;

  // Fixed field and register widths
  localparam int SIZE_W    = 11;
  localparam int INV_DT_W  = 16;
  localparam int COORD_W   = 10;
  localparam int GXY_W     = 11;
  localparam int GT_W      = 15;
  localparam int FRAC_W    = 12;
  localparam int CFG_IDX_W = 2;
  localparam int OUT_W     = 64;

  // Frame size limits
  localparam int MIN_SIZE   = 3;
  localparam int SIZE_LIMIT = 1024;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_DT     = 2'd2;

  // Reset value of the time-step reciprocal (1.0 in Q4.12)
  localparam logic [INV_DT_W-1:0] INV_DT_RST = 16'd4096;

  // Raster position carried along the pipeline
  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } pos_t;

endpackage

// ----- rtl/core/stg_ram.sv -----
module stg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port, registered read port (read returns the old word on a collision)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/stg_line.sv -----
module stg_line #(
  parameter int MAX_WIDTH  = stg_pkg::MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = stg_pkg::PIXEL_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [2*PIXEL_BITS-1:0]     in_pair,
  input  logic [stg_pkg::SIZE_W-1:0]  cols,
  input  logic [stg_pkg::SIZE_W-1:0]  rows,
  output logic                        s1_valid,
  input  logic                        s1_ready,
  output stg_pkg::pos_t               s1_pos,
  output logic [2*PIXEL_BITS-1:0]     s1_cur,
  output logic [2*PIXEL_BITS-1:0]     s1_up
);

  localparam int COUNT_LIMIT = (MAX_WIDTH < stg_pkg::SIZE_LIMIT) ? MAX_WIDTH
                                                                 : stg_pkg::SIZE_LIMIT;
  localparam int AW = (COUNT_LIMIT > 1) ? $clog2(COUNT_LIMIT) : 1;
  localparam int PW = 2 * PIXEL_BITS;

  logic [stg_pkg::COORD_W-1:0] col_r, col_nxt, row_r, row_nxt;
  logic [stg_pkg::COORD_W-1:0] col_snap, row_snap;
  logic [stg_pkg::SIZE_W-1:0]  fill_r, fill_nxt;
  logic                        last_col, last_row, accept, up_ok;
  logic                        s1_v_r, up_ok_r;
  stg_pkg::pos_t               pos_r;
  logic [PW-1:0]               cur_r, ram_rdata;

  assign in_ready = !s1_v_r || s1_ready;
  assign accept   = in_valid && in_ready;

  // Snap counts that lie beyond a shrunk frame size back to zero
  assign col_snap = ({1'b0, col_r} >= cols) ? '0 : col_r;
  assign row_snap = ({1'b0, row_r} >= rows) ? '0 : row_r;
  assign last_col = ({1'b0, col_snap} + stg_pkg::SIZE_W'(1)) >= cols;
  assign last_row = ({1'b0, row_snap} + stg_pkg::SIZE_W'(1)) >= rows;

  // Advance the raster position
  always_comb begin
    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : row_snap + 1'b1;
    end else begin
      col_nxt = col_snap + 1'b1;
      row_nxt = row_snap;
    end
  end

  // Columns are visited in order from zero, so entries below the fill mark hold data
  assign up_ok    = {1'b0, col_snap} < fill_r;
  assign fill_nxt = up_ok ? fill_r : {1'b0, col_snap} + stg_pkg::SIZE_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      fill_r <= '0;
      s1_v_r <= 1'b0;
    end else begin
      if (accept) begin
        col_r  <= col_nxt;
        row_r  <= row_nxt;
        fill_r <= fill_nxt;
      end
      if (in_ready) begin
        s1_v_r <= in_valid;
      end
    end
  end

  // Hold the stage payload alongside the line store read
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_r   <= in_pair;
      pos_r   <= '{col: col_snap, row: row_snap};
      up_ok_r <= up_ok;
    end
  end

  // Previous row of pixel pairs, read and overwritten at the same column
  stg_ram #(
    .WIDTH (PW),
    .DEPTH (COUNT_LIMIT)
  ) u_line_ram (
    .clk   (clk),
    .we    (accept),
    .waddr (col_snap[AW-1:0]),
    .wdata (in_pair),
    .re    (accept),
    .raddr (col_snap[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign s1_valid = s1_v_r;
  assign s1_pos   = pos_r;
  assign s1_cur   = cur_r;
  assign s1_up    = up_ok_r ? ram_rdata : '0;

endmodule

// ----- rtl/core/stg_diff.sv -----
module stg_diff #(
  parameter int PIXEL_BITS = stg_pkg::PIXEL_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           s1_valid,
  output logic                           s1_ready,
  input  stg_pkg::pos_t                  s1_pos,
  input  logic [2*PIXEL_BITS-1:0]        s1_cur,
  input  logic [2*PIXEL_BITS-1:0]        s1_up,
  output logic                           s2_valid,
  input  logic                           s2_ready,
  output logic                           s2_emit,
  output stg_pkg::pos_t                  s2_pos,
  output logic signed [PIXEL_BITS+2:0]   s2_gx,
  output logic signed [PIXEL_BITS+2:0]   s2_gy,
  output logic signed [PIXEL_BITS+2:0]   s2_st
);

  localparam int PW = 2 * PIXEL_BITS;
  localparam int GW = PIXEL_BITS + 3;

  logic [PW-1:0]          left_r, uleft_r;
  logic                   take, emit, full;
  logic signed [GW-1:0]   a00, a10, a01, a11, b00, b10, b01, b11;
  logic signed [GW-1:0]   gx, gy, st;
  logic                   s2_v_r, emit_r;
  stg_pkg::pos_t          pos_r;
  logic signed [GW-1:0]   gx_r, gy_r, st_r;

  assign s1_ready = !s2_v_r || s2_ready;
  assign take     = s1_valid && s1_ready;

  assign emit = (s1_pos.col != '0) && (s1_pos.row != '0);
  assign full = (s1_pos.col > stg_pkg::COORD_W'(1)) && (s1_pos.row > stg_pkg::COORD_W'(1));

  // Corners of the cube: 00 upper left, 10 upper, 01 left, 11 current
  assign a00 = GW'(uleft_r[PIXEL_BITS-1:0]);
  assign b00 = GW'(uleft_r[PW-1:PIXEL_BITS]);
  assign a10 = GW'(s1_up[PIXEL_BITS-1:0]);
  assign b10 = GW'(s1_up[PW-1:PIXEL_BITS]);
  assign a01 = GW'(left_r[PIXEL_BITS-1:0]);
  assign b01 = GW'(left_r[PW-1:PIXEL_BITS]);
  assign a11 = GW'(s1_cur[PIXEL_BITS-1:0]);
  assign b11 = GW'(s1_cur[PW-1:PIXEL_BITS]);

  // Sum the four differences along each axis; border cubes give zero
  always_comb begin
    gx = '0;
    gy = '0;
    st = '0;
    if (full) begin
      gx = (a10 - a00) + (a11 - a01) + (b10 - b00) + (b11 - b01);
      gy = (a01 - a00) + (a11 - a10) + (b01 - b00) + (b11 - b10);
      st = (b00 - a00) + (b10 - a10) + (b01 - a01) + (b11 - a11);
    end
  end

  // Shift the neighbor window on every transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r  <= '0;
      uleft_r <= '0;
      s2_v_r  <= 1'b0;
    end else begin
      if (take) begin
        left_r  <= s1_cur;
        uleft_r <= s1_up;
      end
      if (s1_ready) begin
        s2_v_r <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      emit_r <= emit;
      pos_r  <= '{col: s1_pos.col - 1'b1, row: s1_pos.row - 1'b1};
      gx_r   <= gx;
      gy_r   <= gy;
      st_r   <= st;
    end
  end

  assign s2_valid = s2_v_r;
  assign s2_emit  = emit_r;
  assign s2_pos   = pos_r;
  assign s2_gx    = gx_r;
  assign s2_gy    = gy_r;
  assign s2_st    = st_r;

endmodule

// ----- rtl/core/stg_scale.sv -----
module stg_scale #(
  parameter int PIXEL_BITS = stg_pkg::PIXEL_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                s2_valid,
  output logic                                s2_ready,
  input  logic                                s2_emit,
  input  stg_pkg::pos_t                       s2_pos,
  input  logic signed [PIXEL_BITS+2:0]        s2_gx,
  input  logic signed [PIXEL_BITS+2:0]        s2_gy,
  input  logic signed [PIXEL_BITS+2:0]        s2_st,
  input  logic [stg_pkg::INV_DT_W-1:0]        inv_dt,
  output logic                                out_valid,
  input  logic                                out_ready,
  output stg_pkg::pos_t                       out_pos,
  output logic [stg_pkg::GXY_W-1:0]           out_gx,
  output logic [stg_pkg::GXY_W-1:0]           out_gy,
  output logic [stg_pkg::GT_W-1:0]            out_gt
);

  localparam int GW  = PIXEL_BITS + 3;
  localparam int PRW = GW + stg_pkg::INV_DT_W + 1;
  localparam int QW  = PRW - stg_pkg::FRAC_W;
  localparam int XW  = (GW > stg_pkg::GXY_W) ? GW : stg_pkg::GXY_W;
  localparam int TW  = (QW > stg_pkg::GT_W) ? QW : stg_pkg::GT_W;
  localparam logic signed [XW-1:0] XY_HI = XW'((1 << (stg_pkg::GXY_W - 1)) - 1);
  localparam logic signed [XW-1:0] XY_LO = -XY_HI - XW'(1);
  localparam logic signed [TW-1:0] T_HI  = TW'((1 << (stg_pkg::GT_W - 1)) - 1);
  localparam logic signed [TW-1:0] T_LO  = -T_HI - TW'(1);

  logic signed [stg_pkg::INV_DT_W:0] inv_s;
  logic signed [PRW-1:0]             prod, prod_b;
  logic signed [QW-1:0]              quo;
  logic signed [XW-1:0]              gx_x, gy_x;
  logic signed [TW-1:0]              gt_x;
  logic [stg_pkg::GXY_W-1:0]         gx_s, gy_s;
  logic [stg_pkg::GT_W-1:0]          gt_s;
  logic                              take;
  logic                              out_v_r;
  stg_pkg::pos_t                     pos_r;
  logic [stg_pkg::GXY_W-1:0]         gx_r, gy_r;
  logic [stg_pkg::GT_W-1:0]          gt_r;

  assign s2_ready = !out_v_r || out_ready;
  assign take     = s2_valid && s2_ready;

  // Scale the temporal sum by Q4.12 inv_dt and truncate toward zero
  assign inv_s  = {1'b0, inv_dt};
  assign prod   = PRW'(s2_st) * PRW'(inv_s);
  assign prod_b = prod + $signed({{(PRW - stg_pkg::FRAC_W){1'b0}},
                                  {stg_pkg::FRAC_W{prod[PRW-1]}}});
  assign quo    = QW'(prod_b >>> stg_pkg::FRAC_W);

  // Saturate all three to their field widths
  assign gx_x = XW'(s2_gx);
  assign gy_x = XW'(s2_gy);
  assign gt_x = TW'(quo);

  always_comb begin
    if (gx_x > XY_HI)       gx_s = XY_HI[stg_pkg::GXY_W-1:0];
    else if (gx_x < XY_LO)  gx_s = XY_LO[stg_pkg::GXY_W-1:0];
    else                    gx_s = gx_x[stg_pkg::GXY_W-1:0];
    if (gy_x > XY_HI)       gy_s = XY_HI[stg_pkg::GXY_W-1:0];
    else if (gy_x < XY_LO)  gy_s = XY_LO[stg_pkg::GXY_W-1:0];
    else                    gy_s = gy_x[stg_pkg::GXY_W-1:0];
    if (gt_x > T_HI)        gt_s = T_HI[stg_pkg::GT_W-1:0];
    else if (gt_x < T_LO)   gt_s = T_LO[stg_pkg::GT_W-1:0];
    else                    gt_s = gt_x[stg_pkg::GT_W-1:0];
  end

  // Drop items that produce no result at the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s2_ready) begin
      out_v_r <= s2_valid && s2_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pos_r <= s2_pos;
      gx_r  <= gx_s;
      gy_r  <= gy_s;
      gt_r  <= gt_s;
    end
  end

  assign out_valid = out_v_r;
  assign out_pos   = pos_r;
  assign out_gx    = gx_r;
  assign out_gy    = gy_r;
  assign out_gt    = gt_r;

endmodule

// ----- rtl/core/spatiotemporal_gradient_2x2x2.sv -----
// Channel | Direction | Handshake          | Payload
// in_     | input     | in_tvalid/tready   | in_tdata: pixel_a, pixel_b
// out_    | output    | out_tvalid/tready  | out_tdata: grad_x, grad_y, grad_t, out_col, out_row
// cfg_    | input     | cfg_we             | cfg_idx, cfg_data (image_cols, image_rows, inv_dt)
//
// One pixel pair per clock while out_tready does not stall the pipeline; the result passes
// through the registered line store read, the difference stage and the scaling stage.
// Reset is synchronous; the line store needs no clearing pass, a fill mark makes
// columns not yet written read as zero, so input is taken right after reset.
// A stalled output holds its register; each stage refills as soon as it empties.
module spatiotemporal_gradient_2x2x2 #(
  parameter int MAX_WIDTH  = stg_pkg::MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = stg_pkg::PIXEL_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // pixel_a, pixel_b
  input  logic [((2*PIXEL_BITS+7)/8)*8-1:0]      in_tdata,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // grad_x[10:0], grad_y[21:11], grad_t[36:22], out_col[46:37], out_row[56:47]
  output logic [stg_pkg::OUT_W-1:0]              out_tdata,
  input  logic                                   cfg_we,
  input  logic [stg_pkg::CFG_IDX_W-1:0]          cfg_idx,
  input  logic [stg_pkg::INV_DT_W-1:0]           cfg_data
);

  localparam int COUNT_LIMIT = (MAX_WIDTH < stg_pkg::SIZE_LIMIT) ? MAX_WIDTH
                                                                 : stg_pkg::SIZE_LIMIT;
  localparam int GW = PIXEL_BITS + 3;
  localparam int PAD_W = stg_pkg::OUT_W - 2 * stg_pkg::GXY_W - stg_pkg::GT_W
                         - 2 * stg_pkg::COORD_W;

  logic [stg_pkg::SIZE_W-1:0]   cols_r, rows_r;
  logic [stg_pkg::INV_DT_W-1:0] inv_dt_r;

  logic                         s1_valid, s1_ready, s2_valid, s2_ready, s2_emit;
  stg_pkg::pos_t                s1_pos, s2_pos, out_pos;
  logic [2*PIXEL_BITS-1:0]      s1_cur, s1_up;
  logic signed [GW-1:0]         s2_gx, s2_gy, s2_st;
  logic [stg_pkg::GXY_W-1:0]    out_gx, out_gy;
  logic [stg_pkg::GT_W-1:0]     out_gt;

  function automatic logic [stg_pkg::SIZE_W-1:0] clamp_size(
    input logic [stg_pkg::SIZE_W-1:0] v
  );
    if (v < stg_pkg::SIZE_W'(stg_pkg::MIN_SIZE)) begin
      return stg_pkg::SIZE_W'(stg_pkg::MIN_SIZE);
    end else if (v > stg_pkg::SIZE_W'(COUNT_LIMIT)) begin
      return stg_pkg::SIZE_W'(COUNT_LIMIT);
    end
    return v;
  endfunction

  // Configuration registers; frame sizes are kept already clamped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r   <= stg_pkg::SIZE_W'(COUNT_LIMIT);
      rows_r   <= stg_pkg::SIZE_W'(COUNT_LIMIT);
      inv_dt_r <= stg_pkg::INV_DT_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        stg_pkg::CFG_IMAGE_COLS: cols_r   <= clamp_size(cfg_data[stg_pkg::SIZE_W-1:0]);
        stg_pkg::CFG_IMAGE_ROWS: rows_r   <= clamp_size(cfg_data[stg_pkg::SIZE_W-1:0]);
        stg_pkg::CFG_INV_DT:     inv_dt_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  stg_line #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_line (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_pair  (in_tdata[2*PIXEL_BITS-1:0]),
    .cols     (cols_r),
    .rows     (rows_r),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1_pos   (s1_pos),
    .s1_cur   (s1_cur),
    .s1_up    (s1_up)
  );

  stg_diff #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_diff (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1_pos   (s1_pos),
    .s1_cur   (s1_cur),
    .s1_up    (s1_up),
    .s2_valid (s2_valid),
    .s2_ready (s2_ready),
    .s2_emit  (s2_emit),
    .s2_pos   (s2_pos),
    .s2_gx    (s2_gx),
    .s2_gy    (s2_gy),
    .s2_st    (s2_st)
  );

  stg_scale #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .s2_valid  (s2_valid),
    .s2_ready  (s2_ready),
    .s2_emit   (s2_emit),
    .s2_pos    (s2_pos),
    .s2_gx     (s2_gx),
    .s2_gy     (s2_gy),
    .s2_st     (s2_st),
    .inv_dt    (inv_dt_r),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_pos   (out_pos),
    .out_gx    (out_gx),
    .out_gy    (out_gy),
    .out_gt    (out_gt)
  );

  // Pack the result fields, lowest first
  assign out_tdata = {{PAD_W{1'b0}}, out_pos.row, out_pos.col, out_gt, out_gy, out_gx};

  // Frame sizes stay inside the supported range
  a_cols_range: assert property (@(posedge clk) disable iff (!rst_n)
    cols_r >= stg_pkg::SIZE_W'(stg_pkg::MIN_SIZE) && cols_r <= stg_pkg::SIZE_W'(COUNT_LIMIT))
    else $error("column count register out of range");

  a_rows_range: assert property (@(posedge clk) disable iff (!rst_n)
    rows_r >= stg_pkg::SIZE_W'(stg_pkg::MIN_SIZE) && rows_r <= stg_pkg::SIZE_W'(COUNT_LIMIT))
    else $error("row count register out of range");

  // The last row and column of the field are never emitted
  a_pos_inside: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ({1'b0, out_pos.col} + stg_pkg::SIZE_W'(2) <= cols_r) &&
                   ({1'b0, out_pos.row} + stg_pkg::SIZE_W'(2) <= rows_r))
    else $error("result emitted for last row or column");

  // Border positions carry zero derivatives
  a_border_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_pos.col == '0 || out_pos.row == '0)
      |-> out_gx == '0 && out_gy == '0 && out_gt == '0)
    else $error("nonzero derivative on border position");

endmodule

// ----- test/tb_spatiotemporal_gradient_2x2x2.sv -----
`timescale 1ns / 100ps

module tb_spatiotemporal_gradient_2x2x2;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_ITEMS = 290;
  localparam int SETTLE_CYCLES = 8;
  localparam int WIDE_COLS = 64;

  // One gradient result, laid out as in out_tdata (grad_x in the lowest bits)
  typedef struct packed {
    logic        [stg_pkg::COORD_W-1:0] row;
    logic        [stg_pkg::COORD_W-1:0] col;
    logic signed [stg_pkg::GT_W-1:0]    gt;
    logic signed [stg_pkg::GXY_W-1:0]   gy;
    logic signed [stg_pkg::GXY_W-1:0]   gx;
  } grad_res_t;

  typedef enum logic [1:0] {ROW_PIXEL, ROW_CONFIG} row_kind_t;
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_TYPED} row_chk_t;

  // Directed row: a pixel pair {pixel_b, pixel_a} or a register write
  typedef struct packed {
    row_kind_t                     kind;
    logic [stg_pkg::CFG_IDX_W-1:0] idx;
    logic [15:0]                   data;
    row_chk_t                      chk;
    grad_res_t                     want;
  } plan_row_t;

  localparam int PLAN_N = 25;
  localparam plan_row_t PLAN [PLAN_N] = '{
    // reset size: first row of a 1024-wide frame, nothing comes out
    '{ROW_PIXEL, '0, 16'h0000, CHK_NONE, '0},
    '{ROW_PIXEL, '0, 16'hFFFF, CHK_NONE, '0},
    '{ROW_PIXEL, '0, 16'hFF00, CHK_NONE, '0},
    '{ROW_PIXEL, '0, 16'h00FF, CHK_NONE, '0},
    // shrink to 3x3 below the minimum; the column count snaps back to 0
    '{ROW_CONFIG, stg_pkg::CFG_IMAGE_COLS, 16'h0000, CHK_NONE, '0},
    '{ROW_CONFIG, stg_pkg::CFG_IMAGE_ROWS, 16'h0002, CHK_NONE, '0},
    // frame 1: border zeros, then the largest positive x derivative
    '{ROW_PIXEL, '0, 16'h0000, CHK_NONE, '0},
    '{ROW_PIXEL, '0, 16'hFFFF, CHK_NONE, '0},
    '{ROW_PIXEL, '0, 16'hFF00, CHK_NONE, '0},
    '{ROW_PIXEL, '0, 16'h00FF, CHK_NONE, '0},
    '{ROW_PIXEL, '0, 16'h0000, CHK_TYPED, '{10'd0, 10'd0, 15'sd0, 11'sd0, 11'sd0}},
    '{ROW_PIXEL, '0, 16'hFFFF, CHK_TYPED, '{10'd0, 10'd1, 15'sd0, 11'sd0, 11'sd0}},
    '{ROW_PIXEL, '0, 16'h5A3C, CHK_NONE, '0},
    '{ROW_PIXEL, '0, 16'h0000, CHK_TYPED, '{10'd1, 10'd0, 15'sd0, 11'sd0, 11'sd0}},
    '{ROW_PIXEL, '0, 16'hFFFF, CHK_TYPED, '{10'd1, 10'd1, 15'sd0, 11'sd0, 11'sd1020}},
    // frame 2 at the largest time-step reciprocal: borders stay zero
    '{ROW_CONFIG, stg_pkg::CFG_INV_DT, 16'hFFFF, CHK_NONE, '0},
    '{ROW_PIXEL, '0, 16'hFF00, CHK_NONE, '0},
    '{ROW_PIXEL, '0, 16'h0000, CHK_NONE, '0},
    '{ROW_PIXEL, '0, 16'hFFFF, CHK_NONE, '0},
    '{ROW_PIXEL, '0, 16'hFF00, CHK_NONE, '0},
    '{ROW_PIXEL, '0, 16'hFF00, CHK_TYPED, '{10'd0, 10'd0, 15'sd0, 11'sd0, 11'sd0}},
    '{ROW_PIXEL, '0, 16'hFF00, CHK_TYPED, '{10'd0, 10'd1, 15'sd0, 11'sd0, 11'sd0}},
    '{ROW_PIXEL, '0, 16'hFF00, CHK_NONE, '0},
    '{ROW_PIXEL, '0, 16'hFF00, CHK_TYPED, '{10'd1, 10'd0, 15'sd0, 11'sd0, 11'sd0}},
    '{ROW_PIXEL, '0, 16'hFF00, CHK_MODEL, '0}
  };

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_tvalid = 1'b0;
  logic                          in_tready;
  logic [15:0]                   in_tdata = '0;   // pixel_a[7:0], pixel_b[15:8]
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [stg_pkg::OUT_W-1:0]     out_tdata;       // grad_x, grad_y, grad_t, out_col, out_row
  logic                          cfg_we = 1'b0;
  logic [stg_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
  logic [stg_pkg::INV_DT_W-1:0]  cfg_data = '0;

  // Gradient predictor state
  logic [15:0]                  line_mem [stg_pkg::SIZE_LIMIT];
  logic [15:0]                  left_px;
  logic [15:0]                  upleft_px;
  int unsigned                  col_cnt;
  int unsigned                  row_cnt;
  logic [stg_pkg::SIZE_W-1:0]   size_cols;
  logic [stg_pkg::SIZE_W-1:0]   size_rows;
  logic [stg_pkg::INV_DT_W-1:0] inv_dt;

  grad_res_t   pending_grads [$];
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned stall_left = 0;
  bit          steady = 1'b0;
  grad_res_t   got_grad;
  grad_res_t   want_grad;

  spatiotemporal_gradient_2x2x2 uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic int unsigned idle_len();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int unsigned size_clamp(input logic [stg_pkg::SIZE_W-1:0] v);
    if (v < stg_pkg::MIN_SIZE) return stg_pkg::MIN_SIZE;
    if (v > stg_pkg::SIZE_LIMIT) return stg_pkg::SIZE_LIMIT;
    return v;
  endfunction

  function automatic void gradient_reset();
    foreach (line_mem[i]) line_mem[i] = '0;
    left_px = '0;
    upleft_px = '0;
    col_cnt = 0;
    row_cnt = 0;
    size_cols = stg_pkg::SIZE_W'(stg_pkg::SIZE_LIMIT);
    size_rows = stg_pkg::SIZE_W'(stg_pkg::SIZE_LIMIT);
    inv_dt = stg_pkg::INV_DT_RST;
  endfunction

  // Advance the predictor by one pixel pair; return 1 when a result is due
  function automatic bit cube_gradient(input logic [7:0] pa, input logic [7:0] pb,
                                       output grad_res_t res);
    int unsigned cols, rows, c, r;
    logic [15:0] cur, up;
    int a00, b00, a10, b10, a01, b01, a11, b11, gx, gy, st;
    longint prod, mag;
    bit hit;
    cols = size_clamp(size_cols);
    rows = size_clamp(size_rows);
    // snap counts that a smaller size has left out of range
    if (col_cnt >= cols) col_cnt = 0;
    if (row_cnt >= rows) row_cnt = 0;
    c = col_cnt;
    r = row_cnt;
    cur = {pb, pa};
    up = line_mem[c];
    res = '0;
    hit = (c >= 1) && (r >= 1);
    if (c >= 2 && r >= 2) begin
      a00 = upleft_px[7:0]; b00 = upleft_px[15:8];
      a10 = up[7:0];        b10 = up[15:8];
      a01 = left_px[7:0];   b01 = left_px[15:8];
      a11 = cur[7:0];       b11 = cur[15:8];
      gx = (a10 - a00) + (a11 - a01) + (b10 - b00) + (b11 - b01);
      gy = (a01 - a00) + (a11 - a10) + (b01 - b00) + (b11 - b10);
      st = (b00 - a00) + (b10 - a10) + (b01 - a01) + (b11 - a11);
      // scale by Q4.12 and truncate toward zero
      prod = longint'(st) * longint'(inv_dt);
      mag = (prod < 0 ? -prod : prod) >>> stg_pkg::FRAC_W;
      res.gx = gx[stg_pkg::GXY_W-1:0];
      res.gy = gy[stg_pkg::GXY_W-1:0];
      res.gt = (prod < 0) ? stg_pkg::GT_W'(-mag) : stg_pkg::GT_W'(mag);
    end
    if (hit) begin
      res.col = stg_pkg::COORD_W'(c - 1);
      res.row = stg_pkg::COORD_W'(r - 1);
    end
    upleft_px = up;
    left_px = cur;
    line_mem[c] = cur;
    if (c + 1 >= cols) begin
      col_cnt = 0;
      row_cnt = (r + 1 >= rows) ? 0 : r + 1;
    end else begin
      col_cnt = c + 1;
    end
    return hit;
  endfunction

  function automatic void field_check(input string what, input int want_v, input int got_v);
    if (want_v != got_v) begin
      $display("%0t: %s expected %0d got %0d", $time, what, want_v, got_v);
      mismatch_cnt++;
    end
  endfunction

  // Drive out_tready with random stalls
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (steady || $urandom_range(0, 99) < 70) begin
      out_tready <= 1'b1;
    end else begin
      stall_left = idle_len();
      out_tready <= 1'b0;
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_grad = grad_res_t'(out_tdata[$bits(grad_res_t)-1:0]);
      if (pending_grads.size() == 0) begin
        $display("%0t: unexpected result, expected none got %h", $time, got_grad);
        mismatch_cnt++;
      end else begin
        want_grad = pending_grads.pop_front();
        field_check("grad_x", want_grad.gx, got_grad.gx);
        field_check("grad_y", want_grad.gy, got_grad.gy);
        field_check("grad_t", want_grad.gt, got_grad.gt);
        field_check("out_col", want_grad.col, got_grad.col);
        field_check("out_row", want_grad.row, got_grad.row);
      end
    end
  end

  // Send one pixel pair, after an optional gap; return at the next falling edge
  task automatic send_pixel(input logic [15:0] pair, output grad_res_t res, output bit hit);
    if (!steady && $urandom_range(0, 99) < 35) begin
      in_tvalid <= 1'b0;
      repeat (idle_len()) @(negedge clk);
    end
    in_tdata <= pair;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    hit = cube_gradient(pair[7:0], pair[15:8], res);
    @(negedge clk);
  endtask

  // Drop valid and wait until every expected result is out
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_grads.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic cfg_write(input logic [stg_pkg::CFG_IDX_W-1:0] idx,
                           input logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      stg_pkg::CFG_IMAGE_COLS: size_cols = value[stg_pkg::SIZE_W-1:0];
      stg_pkg::CFG_IMAGE_ROWS: size_rows = value[stg_pkg::SIZE_W-1:0];
      stg_pkg::CFG_INV_DT:     inv_dt = value;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic run_pixels(input int unsigned n);
    logic [7:0] pa, pb;
    grad_res_t res;
    bit hit;
    repeat (n) begin
      pa = ($urandom_range(0, 99) < 20) ? {8{1'($urandom_range(0, 1))}} : 8'($urandom);
      pb = ($urandom_range(0, 99) < 20) ? {8{1'($urandom_range(0, 1))}} : 8'($urandom);
      send_pixel({pb, pa}, res, hit);
      if (hit) pending_grads.push_back(res);
    end
    in_tvalid <= 1'b0;
  endtask

  function automatic logic [15:0] pick_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 16'($urandom_range(3, 10));
    if (r < 82) return 16'($urandom_range(0, 2));
    if (r < 92) return 16'($urandom_range(11, 40));
    if (r < 96) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_inv_dt();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return 16'h0000;
    if (r < 30) return 16'hFFFF;
    if (r < 40) return stg_pkg::INV_DT_RST;
    return 16'($urandom);
  endfunction

  initial begin
    grad_res_t res;
    bit hit;
    int unsigned sent;
    int unsigned burst;
    gradient_reset();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Walk the directed table
    for (int k = 0; k < PLAN_N; k++) begin
      if (PLAN[k].kind == ROW_CONFIG) begin
        settle();
        cfg_write(PLAN[k].idx, PLAN[k].data);
      end else begin
        send_pixel(PLAN[k].data, res, hit);
        case (PLAN[k].chk)
          CHK_MODEL: if (hit) pending_grads.push_back(res);
          CHK_TYPED: pending_grads.push_back(PLAN[k].want);
          default: ;
        endcase
      end
    end

    // Random phases, each under a fresh setting
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      settle();
      steady = ($urandom_range(0, 3) == 0);
      cfg_write(stg_pkg::CFG_IMAGE_COLS, pick_size());
      if ($urandom_range(0, 1)) cfg_write(stg_pkg::CFG_IMAGE_ROWS, pick_size());
      if ($urandom_range(0, 1)) cfg_write(stg_pkg::CFG_INV_DT, pick_inv_dt());
      burst = $urandom_range(8, 60);
      run_pixels(burst);
      sent += burst;
    end

    // Wider frame, three rows: run past the end of two full rows
    settle();
    steady = 1'b0;
    cfg_write(stg_pkg::CFG_IMAGE_COLS, 16'(WIDE_COLS));
    cfg_write(stg_pkg::CFG_IMAGE_ROWS, 16'h0000);
    cfg_write(stg_pkg::CFG_INV_DT, pick_inv_dt());
    run_pixels(2 * WIDE_COLS + 4);

    settle();
    if (mismatch_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
